// ----- hw/rtl/bale_pkg.sv -----
package bale_pkg;

	// Field widths of the command and response words
	localparam int MODE_W   = 3;
	localparam int POS_W    = 6;
	localparam int WORD_W   = 32;
	localparam int STAT_W   = 3;
	localparam int CNT_W    = 7;

	// Store depth default and capacity register reset value
	localparam int STORE_DEPTH_DEF = 64;
	localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [MODE_W-1:0] {
		MODE_APPEND = 3'd0,
		MODE_INSERT = 3'd1,
		MODE_EDIT   = 3'd2,
		MODE_DELETE = 3'd3,
		MODE_READ   = 3'd4,
		MODE_FIND   = 3'd5
	} bale_mode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_FULL      = 3'd1,
		STAT_EMPTY     = 3'd2,
		STAT_BAD_POS   = 3'd3,
		STAT_NOT_FOUND = 3'd4
	} bale_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN
	} bale_state_t;

	// What a cell does with its word in the current cycle
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FROM_LOWER,
		CELL_FROM_UPPER
	} bale_cell_sel_t;

	typedef struct packed {
		bale_cell_sel_t sel;
		logic           cmp;
	} bale_cell_ctrl_t;

	typedef struct packed {
		logic [MODE_W-1:0]        mode;
		logic [POS_W-1:0]         position;
		logic signed [WORD_W-1:0] value;
	} bale_cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic signed [WORD_W-1:0] read_value;
		logic [POS_W-1:0]         found_position;
		logic [CNT_W-1:0]         entry_count;
		logic                     is_empty;
		logic                     is_full;
	} bale_rsp_t;

endpackage

// ----- hw/rtl/bale_cell.sv -----
module bale_cell (
	input  logic                                  clk,
	input  bale_pkg::bale_cell_ctrl_t             ctrl,
	input  logic signed [bale_pkg::WORD_W-1:0]    value,
	input  logic signed [bale_pkg::WORD_W-1:0]    lower_word,
	input  logic signed [bale_pkg::WORD_W-1:0]    upper_word,
	output logic signed [bale_pkg::WORD_W-1:0]    word,
	output logic                                  hit
);

	logic signed [bale_pkg::WORD_W-1:0] word_q;
	logic                               hit_q;

	// Hold, load, or take the word of a neighbor
	always_ff @(posedge clk) begin
		unique case (ctrl.sel)
			bale_pkg::CELL_HOLD:       word_q <= word_q;
			bale_pkg::CELL_LOAD:       word_q <= value;
			bale_pkg::CELL_FROM_LOWER: word_q <= lower_word;
			bale_pkg::CELL_FROM_UPPER: word_q <= upper_word;
			default:                   word_q <= word_q;
		endcase
	end

	// Compare the stored word against the search key
	always_ff @(posedge clk) begin
		hit_q <= ctrl.cmp && (word_q == value);
	end

	assign word = word_q;
	assign hit  = hit_q;

endmodule

// ----- hw/rtl/bounded_array_list_engine.sv -----
// From the accepting edge a command passes the EXEC and SCAN states before the done strobe.
// A new command is taken only while busy is low, after SCAN (cell update, match scan, response).
// Every command, find included, takes the same path; the whole cell row updates in the same cycle.
// Reset (arst_n low) empties the list and sets the capacity to 64; stored words are not cleared.
// The receiver cannot stall: done and rsp are valid for exactly one cycle.
module bounded_array_list_engine #(
	parameter int STORE_DEPTH = bale_pkg::STORE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  bale_pkg::bale_cmd_t             cmd,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bale_pkg::CNT_W-1:0]      cfg_data,
	output logic                            done,
	output bale_pkg::bale_rsp_t             rsp
);

	localparam int IDXW = $clog2(STORE_DEPTH);
	localparam int DW   = $clog2(STORE_DEPTH + 1);
	localparam int CW   = (bale_pkg::CNT_W > DW) ? bale_pkg::CNT_W : DW;
	localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

	bale_pkg::bale_state_t state_q, state_d;
	bale_pkg::bale_cmd_t   cmd_q;
	bale_pkg::bale_rsp_t   rsp_q;
	bale_pkg::bale_status_t status_q;
	logic [bale_pkg::CNT_W-1:0] count_q;
	logic [bale_pkg::CNT_W-1:0] cap_q;
	logic signed [bale_pkg::WORD_W-1:0] rd_q;
	logic done_q;

	logic exec_en, scan_en, accept;
	logic [CW-1:0] n_c, p_c, cap_c, eff_c;
	logic full, pos_in, pos_ins_ok;
	bale_pkg::bale_mode_t mode;

	bale_pkg::bale_cell_ctrl_t ctrl [STORE_DEPTH];
	logic signed [bale_pkg::WORD_W-1:0] words [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] hits;
	logic [IDXW-1:0] rd_idx, hit_idx;
	logic hit_any;

	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= bale_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bale_pkg::ST_IDLE: if (start) state_d = bale_pkg::ST_EXEC;
			bale_pkg::ST_EXEC: state_d = bale_pkg::ST_SCAN;
			bale_pkg::ST_SCAN: state_d = bale_pkg::ST_IDLE;
			default:           state_d = bale_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		busy    = 1'b1;
		exec_en = 1'b0;
		scan_en = 1'b0;
		unique case (state_q)
			bale_pkg::ST_IDLE: busy = 1'b0;
			bale_pkg::ST_EXEC: exec_en = 1'b1;
			bale_pkg::ST_SCAN: scan_en = 1'b1;
			default:           busy = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bale_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Latch the command word
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
	end

	// Effective capacity: limit to the store depth, zero counts as one
	always_comb begin
		cap_c = CW'(cap_q);
		eff_c = cap_c;
		if (cap_c > DEPTH_C) begin
			eff_c = DEPTH_C;
		end
		if (cap_c == '0) begin
			eff_c = CW'(1);
		end
	end

	assign mode       = bale_pkg::bale_mode_t'(cmd_q.mode);
	assign n_c        = CW'(count_q);
	assign p_c        = CW'(cmd_q.position);
	assign full       = n_c >= eff_c;
	assign pos_in     = p_c < n_c;
	assign pos_ins_ok = p_c <= n_c;

	// Per-cell control from the command and the fill count
	for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_ctrl
		localparam logic [CW-1:0] I_C  = CW'(i);
		localparam logic [CW-1:0] I1_C = CW'(i + 1);
		always_comb begin
			ctrl[i].sel = bale_pkg::CELL_HOLD;
			ctrl[i].cmp = 1'b0;
			if (exec_en) begin
				unique case (mode)
					bale_pkg::MODE_APPEND:
						if (!full && I_C == n_c) ctrl[i].sel = bale_pkg::CELL_LOAD;
					bale_pkg::MODE_INSERT:
						if (!full && pos_ins_ok) begin
							if (I_C == p_c) begin
								ctrl[i].sel = bale_pkg::CELL_LOAD;
							end else if (I_C > p_c && I_C <= n_c) begin
								ctrl[i].sel = bale_pkg::CELL_FROM_LOWER;
							end
						end
					bale_pkg::MODE_EDIT:
						if (pos_in && I_C == p_c) ctrl[i].sel = bale_pkg::CELL_LOAD;
					bale_pkg::MODE_DELETE:
						if (pos_in && I_C >= p_c && I1_C < n_c) begin
							ctrl[i].sel = bale_pkg::CELL_FROM_UPPER;
						end
					bale_pkg::MODE_FIND:
						ctrl[i].cmp = I_C < n_c;
					default: ;
				endcase
			end
		end
	end

	// Row of word cells
	for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
		logic signed [bale_pkg::WORD_W-1:0] lower_w, upper_w;
		if (i == 0) begin : g_first
			assign lower_w = '0;
		end else begin : g_mid_lo
			assign lower_w = words[i-1];
		end
		if (i == STORE_DEPTH - 1) begin : g_last
			assign upper_w = '0;
		end else begin : g_mid_hi
			assign upper_w = words[i+1];
		end
		bale_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl[i]),
			.value      (cmd_q.value),
			.lower_word (lower_w),
			.upper_word (upper_w),
			.word       (words[i]),
			.hit        (hits[i])
		);
	end

	// Execute: status, count update, read word
	assign rd_idx = IDXW'(cmd_q.position);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (exec_en) begin
			unique case (mode)
				bale_pkg::MODE_APPEND:
					if (!full) count_q <= count_q + 1'b1;
				bale_pkg::MODE_INSERT:
					if (!full && pos_ins_ok) count_q <= count_q + 1'b1;
				bale_pkg::MODE_DELETE:
					if (pos_in) count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (exec_en) begin
			status_q <= bale_pkg::STAT_OK;
			rd_q     <= '0;
			unique case (mode)
				bale_pkg::MODE_APPEND:
					if (full) status_q <= bale_pkg::STAT_FULL;
				bale_pkg::MODE_INSERT:
					if (full) begin
						status_q <= bale_pkg::STAT_FULL;
					end else if (!pos_ins_ok) begin
						status_q <= bale_pkg::STAT_BAD_POS;
					end
				bale_pkg::MODE_EDIT:
					if (!pos_in) status_q <= bale_pkg::STAT_BAD_POS;
				bale_pkg::MODE_DELETE:
					if (n_c == '0) begin
						status_q <= bale_pkg::STAT_EMPTY;
					end else if (!pos_in) begin
						status_q <= bale_pkg::STAT_BAD_POS;
					end
				bale_pkg::MODE_READ:
					if (!pos_in) begin
						status_q <= bale_pkg::STAT_BAD_POS;
					end else begin
						rd_q <= words[rd_idx];
					end
				default: ;
			endcase
		end
	end

	// Lowest matching cell
	always_comb begin
		hit_idx = '0;
		for (int k = STORE_DEPTH - 1; k >= 0; k--) begin
			if (hits[k]) hit_idx = IDXW'(k);
		end
	end
	assign hit_any = |hits;

	// Build the response word
	always_ff @(posedge clk) begin
		if (scan_en) begin
			rsp_q.read_value     <= rd_q;
			rsp_q.entry_count    <= count_q;
			rsp_q.is_empty       <= count_q == '0;
			rsp_q.is_full        <= full;
			rsp_q.found_position <= '0;
			rsp_q.status         <= status_q;
			if (mode == bale_pkg::MODE_FIND) begin
				if (hit_any) begin
					rsp_q.found_position <= bale_pkg::POS_W'(hit_idx);
				end else begin
					rsp_q.status <= bale_pkg::STAT_NOT_FOUND;
				end
			end
		end
	end

	// Strobe the result for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= scan_en;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ----- hw/rtl/bale_checker.sv -----
module bale_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input bale_pkg::bale_rsp_t        rsp
);

	// Accepted word goes busy at once
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");

	// Result arrives after accept, once the EXEC and SCAN states have passed
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##3 done)
		else $error("result not delivered three cycles after accept");

	// Strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// Empty flag agrees with the count
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.is_empty == (rsp.entry_count == '0)))
		else $error("is_empty disagrees with entry_count");

endmodule

bind bounded_array_list_engine bale_checker u_bale_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
